/* src/buddy_block_allocator_assert.svh */
// Assertion macros used by the buddy allocator sequencer.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("buddy allocator assertion failed");
`define BBA_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("buddy allocator forbidden condition");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_NEVER(lbl, expr)
`endif
`endif

/* src/bba_pkg.sv */
// Package: constants, node codes and store request type of the buddy allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
  localparam int unsigned LEVELS = 8;
  localparam int unsigned LVL_W  = 3;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned NODE_W = LEVELS;
  localparam int unsigned SH_W   = 4;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_SPLIT  = 2'd2,
    ST_ABSENT = 2'd3
  } node_st_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Access from the sequencer to the node store
  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_node;
    logic              wr_en;
    logic [NODE_W-1:0] wr_node;
    node_st_e          wr_st;
  } store_req_t;
endpackage
`default_nettype wire

/* src/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end
endmodule
`default_nettype wire

/* src/bba_node_store.sv */
// Node state store: RAM plus per-node written bits giving the reset tree.
`timescale 1ns / 1ps
`default_nettype none
module bba_node_store import bba_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire store_req_t req_i,
  output node_st_e        rd_st_o
);
  localparam int unsigned DEPTH = 2 ** NODE_W;

  logic [DEPTH-1:0]  written_q;
  logic [NODE_W-1:0] rd_node_q;
  logic [1:0]        ram_rdata;

  bba_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (req_i.wr_en),
    .wr_addr_i (req_i.wr_node),
    .wr_data_i (req_i.wr_st),
    .rd_en_i   (req_i.rd_en),
    .rd_addr_i (req_i.rd_node),
    .rd_data_o (ram_rdata)
  );

  // Written bits: cleared at reset, set on the first write of a node
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (req_i.wr_en) begin
      written_q[req_i.wr_node] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_node_q <= req_i.rd_node;
    end
  end

  // Unwritten node reads as its reset state: root free, rest absent
  always_comb begin
    if (written_q[rd_node_q]) begin
      rd_st_o = node_st_e'(ram_rdata);
    end else if (rd_node_q == NODE_W'(1)) begin
      rd_st_o = ST_FREE;
    end else begin
      rd_st_o = ST_ABSENT;
    end
  end
endmodule
`default_nettype wire

/* src/bba_ctrl.sv */
// Sequencer: walks the buddy tree for allocate and free transactions.
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_assert.svh"
module bba_ctrl import bba_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire logic              op_i,
  input  wire logic [LVL_W-1:0]  level_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output logic                   res_ok_o,
  output logic      [ADDR_W-1:0] res_addr_o,
  output store_req_t             store_o,
  input  wire node_st_e          rd_st_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_SPLIT, S_SIB_FREE, S_FIN,
    S_FFREE, S_FSIB, S_FABS1, S_FABS2, S_RESP
  } state_e;

  state_e            state_q;
  logic              op_q;
  logic [LVL_W-1:0]  req_lvl_q, lvl_q;
  logic [NODE_W-1:0] node_q;
  logic              ok_q;
  logic [ADDR_W-1:0] addr_q;

  logic              accept;
  logic [SH_W-1:0]   in_sh, lvl_sh;
  logic [ADDR_W-1:0] align_mask;
  logic [NODE_W-1:0] free_node, last_node, lvl_mask;
  logic [NODE_W:0]   level_end;

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_ok_o    = ok_q;
  assign res_addr_o  = addr_q;

  // Request decode: node index and alignment of a freed block
  assign in_sh      = SH_W'(ADDR_W) - SH_W'(level_i);
  assign align_mask = (ADDR_W'(1) << in_sh) - ADDR_W'(1);
  assign free_node  = (NODE_W'(1) << level_i) | NODE_W'(addr_i >> in_sh);

  // Level bookkeeping for the current walk position
  assign lvl_sh    = SH_W'(ADDR_W) - SH_W'(lvl_q);
  assign level_end = ((NODE_W+1)'(1) << (SH_W'(lvl_q) + SH_W'(1))) - (NODE_W+1)'(1);
  assign last_node = level_end[NODE_W-1:0];
  assign lvl_mask  = (NODE_W'(1) << lvl_q) - NODE_W'(1);

  // Store access per state
  always_comb begin
    store_o         = '0;
    store_o.wr_st   = ST_FREE;
    store_o.rd_node = node_q;
    store_o.wr_node = node_q;
    case (state_q)
      S_RD:       store_o.rd_en = 1'b1;
      S_SPLIT:    begin
        store_o.wr_en = 1'b1;
        store_o.wr_st = ST_SPLIT;
      end
      S_SIB_FREE: begin
        store_o.wr_en   = 1'b1;
        store_o.wr_node = {node_q[NODE_W-2:0], 1'b1};
        store_o.wr_st   = ST_FREE;
      end
      S_FIN:      begin
        store_o.wr_en = 1'b1;
        store_o.wr_st = ST_ALLOC;
      end
      S_FFREE:    begin
        store_o.wr_en   = 1'b1;
        store_o.wr_st   = ST_FREE;
        store_o.rd_en   = (node_q != NODE_W'(1));
        store_o.rd_node = node_q ^ NODE_W'(1);
      end
      S_FABS1:    begin
        store_o.wr_en = 1'b1;
        store_o.wr_st = ST_ABSENT;
      end
      S_FABS2:    begin
        store_o.wr_en   = 1'b1;
        store_o.wr_node = node_q ^ NODE_W'(1);
        store_o.wr_st   = ST_ABSENT;
      end
      default:    ;
    endcase
  end

  // Sequencer state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ALLOC;
      req_lvl_q <= '0;
      lvl_q     <= '0;
      node_q    <= NODE_W'(1);
      ok_q      <= 1'b0;
      addr_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q      <= op_i;
            req_lvl_q <= level_i;
            lvl_q     <= level_i;
            ok_q      <= 1'b0;
            addr_q    <= '0;
            if (op_i == OP_ALLOC) begin
              node_q  <= NODE_W'(1) << level_i;
              state_q <= S_RD;
            end else if ((addr_i & align_mask) != '0) begin
              state_q <= S_RESP;
            end else begin
              node_q  <= free_node;
              state_q <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          if (op_q == OP_FREE) begin
            state_q <= (rd_st_i == ST_ALLOC) ? S_FFREE : S_RESP;
          end else if (rd_st_i == ST_FREE) begin
            state_q <= (lvl_q == req_lvl_q) ? S_FIN : S_SPLIT;
          end else if (node_q != last_node) begin
            node_q  <= node_q + NODE_W'(1);
            state_q <= S_RD;
          end else if (lvl_q == '0) begin
            state_q <= S_RESP;
          end else begin
            // nothing free here: move one level up
            lvl_q   <= lvl_q - LVL_W'(1);
            node_q  <= NODE_W'(1) << (lvl_q - LVL_W'(1));
            state_q <= S_RD;
          end
        end
        S_SPLIT: state_q <= S_SIB_FREE;
        S_SIB_FREE: begin
          node_q  <= {node_q[NODE_W-2:0], 1'b0};
          lvl_q   <= lvl_q + LVL_W'(1);
          state_q <= (lvl_q + LVL_W'(1) == req_lvl_q) ? S_FIN : S_SPLIT;
        end
        S_FIN: begin
          ok_q    <= 1'b1;
          addr_q  <= ADDR_W'(node_q & lvl_mask) << lvl_sh;
          state_q <= S_RESP;
        end
        S_FFREE: begin
          if (node_q == NODE_W'(1)) begin
            ok_q    <= 1'b1;
            state_q <= S_RESP;
          end else begin
            state_q <= S_FSIB;
          end
        end
        S_FSIB: begin
          if (rd_st_i == ST_FREE) begin
            state_q <= S_FABS1;
          end else begin
            ok_q    <= 1'b1;
            state_q <= S_RESP;
          end
        end
        S_FABS1: state_q <= S_FABS2;
        S_FABS2: begin
          node_q  <= node_q >> 1;
          state_q <= S_FFREE;
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BBA_ASSERT(a_rd_then_chk, (state_q == S_RD) |=> (state_q == S_CHK))
  `BBA_ASSERT(a_accept_next, accept |=> (state_q == S_RD || state_q == S_RESP))
  `BBA_NEVER(a_node_nonzero, (state_q == S_CHK || state_q == S_FFREE) && node_q == '0)
  `BBA_NEVER(a_lvl_range, (state_q == S_SPLIT || state_q == S_FIN) && lvl_q > req_lvl_q)
endmodule
`default_nettype wire

/* src/buddy_block_allocator.sv */
// Buddy block allocator top level: stream ports, result register, tree walk.
//
//  channel   dir  payload (low bit first)           handshake
//  s_axis    in   opcode, level, block_address      tvalid/tready
//  m_axis    out  ok, start_addr                    tvalid/tready
//
// One transaction at a time; each node visit is a registered RAM read,
// then a check. Allocate scans up to 255 nodes, then splits down level by
// level; free checks the block and merges with free buddies toward the
// root, and a misaligned address is rejected without a walk. Reset returns
// the tree to one free root at once through per-node written bits. A waiting
// result sits in the output register while the next transaction is taken.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator import bba_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // opcode, level[3], block_address[10], pad
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o    // ok, start_addr[10], pad
);
  store_req_t        store_req;
  node_st_e          rd_st;
  logic              res_valid, res_ready, res_ok;
  logic [ADDR_W-1:0] res_addr;
  logic              out_valid_q;
  logic              out_ok_q;
  logic [ADDR_W-1:0] out_addr_q;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .op_i        (s_axis_tdata_i[0]),
    .level_i     (s_axis_tdata_i[3:1]),
    .addr_i      (s_axis_tdata_i[13:4]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_ok_o    (res_ok),
    .res_addr_o  (res_addr),
    .store_o     (store_req),
    .rd_st_i     (rd_st)
  );

  bba_node_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rd_st_o(rd_st)
  );

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_ok_q   <= res_ok;
      out_addr_q <= res_addr;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_addr_q, out_ok_q};
endmodule
`default_nettype wire

/* sim/buddy_block_allocator_tb.sv */
// Testbench for the buddy block allocator: stream stimulus, tree predictor, scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_tb;
  import bba_pkg::*;

  // Predictor of the allocator and store of pending results
  class alloc_scoreboard;
    node_st_e tree[1:255];
    logic [10:0] pending_q[$];
    int errors;

    function void clear_tree();
      for (int n = 1; n < 256; n++) tree[n] = ST_ABSENT;
      tree[1] = ST_FREE;
      errors = 0;
    endfunction

    // First free node of a level in address order, 0 if none
    function int first_free(int lvl);
      for (int p = 0; p < (1 << lvl); p++)
        if (tree[(1 << lvl) + p] == ST_FREE) return (1 << lvl) + p;
      return 0;
    endfunction

    function void note_request(logic op, logic [2:0] lvl, logic [9:0] addr);
      int l, node, blk;
      logic ok;
      logic [9:0] sa;
      ok = 1'b0;
      sa = '0;
      blk = 1024 >> lvl;
      if (op == OP_ALLOC) begin
        l = lvl;
        node = first_free(l);
        while (node == 0 && l > 0) begin
          l--;
          node = first_free(l);
        end
        if (node != 0) begin
          while (l < lvl) begin
            tree[node] = ST_SPLIT;
            node = 2 * node;
            tree[node + 1] = ST_FREE;
            l++;
          end
          tree[node] = ST_ALLOC;
          ok = 1'b1;
          sa = 10'((node - (1 << lvl)) * blk);
        end
      end else if (addr % blk == 0) begin
        node = (1 << lvl) + addr / blk;
        if (tree[node] == ST_ALLOC) begin
          tree[node] = ST_FREE;
          // merge with free buddies toward the root
          while (node > 1 && tree[node ^ 1] == ST_FREE) begin
            tree[node] = ST_ABSENT;
            tree[node ^ 1] = ST_ABSENT;
            node = node >> 1;
            tree[node] = ST_FREE;
          end
          ok = 1'b1;
        end
      end
      pending_q.insert(pending_q.size(), {sa, ok});
    endfunction

    function void check_result(logic [15:0] data);
      logic [10:0] exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction %h", data);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (data[0] !== exp_r[0]) begin
        $error("ok: expected %0d, actual %0d", exp_r[0], data[0]);
        errors++;
      end
      if (data[10:1] !== exp_r[10:1]) begin
        $error("start_addr: expected %0d, actual %0d", exp_r[10:1], data[10:1]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic s_ready;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [15:0] m_data;
  bit stim_done = 1'b0;
  alloc_scoreboard sb;
  logic [9:0] live_addr[$];
  logic [2:0] live_lvl[$];

  always #6 clk_i = ~clk_i;

  buddy_block_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // opcode, level[3], block_address[10], pad
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)    // ok, start_addr[10], pad
  );

  // One request transaction; records allocations for later frees
  task automatic send_req(logic op, logic [2:0] lvl, logic [9:0] addr);
    s_valid <= 1'b1;
    s_data <= {2'b00, addr, lvl, op};
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(op, lvl, addr);
    if (op == OP_ALLOC && sb.pending_q[$][0]) begin
      live_addr.insert(live_addr.size(), sb.pending_q[$][10:1]);
      live_lvl.insert(live_lvl.size(), lvl);
    end
  endtask

  task automatic idle_cycles(int n);
    s_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Free a recorded allocation, chosen at random
  task automatic free_live();
    int k;
    k = $urandom_range(live_addr.size() - 1);
    send_req(OP_FREE, live_lvl[k], live_addr[k]);
    live_addr.delete(k);
    live_lvl.delete(k);
  endtask

  // Receiver: rotating pattern of an always-ready phase and a phase with random stalls
  initial begin
    int ph;
    ph = 0;
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) sb.check_result(m_data);
      ph++;
      if (ph % 200 < 60) m_ready <= 1'b1;
      else m_ready <= ($urandom_range(3) != 0) && (ph % 7 != 3);
    end
  end

  initial begin
    int burst;
    sb = new();
    sb.clear_tree();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: whole region, no space, misaligned, double free, all levels
    send_req(OP_ALLOC, 3'd0, 10'd0);
    send_req(OP_ALLOC, 3'd7, 10'd0);
    send_req(OP_FREE, 3'd0, 10'd8);
    send_req(OP_FREE, 3'd0, 10'd0);
    live_addr.delete();
    live_lvl.delete();
    send_req(OP_FREE, 3'd0, 10'd0);
    for (int l = 7; l >= 0; l--) send_req(OP_ALLOC, 3'(l), 10'd0);
    send_req(OP_FREE, 3'd7, 10'd1023);
    send_req(OP_FREE, 3'd1, 10'd512);
    send_req(OP_FREE, 3'd7, 10'd1016);
    while (live_addr.size() > 0) free_live();
    send_req(OP_FREE, 3'd7, 10'd0);
    send_req(OP_ALLOC, 3'd7, 10'h3ff);
    send_req(OP_FREE, 3'd7, 10'd0);
    // Pause until all results are back
    s_valid <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    // Random: mostly alloc/free of live blocks, some garbage frees
    burst = 0;
    for (int i = 0; i < 1850; i++) begin
      if (burst == 0) begin
        idle_cycles($urandom_range(40));
        burst = $urandom_range(1, 30);
      end
      burst--;
      case ($urandom_range(9))
        0: send_req(OP_FREE, 3'($urandom), 10'($urandom));
        1, 2, 3, 4: begin
          if (live_addr.size() > 0) free_live();
          else send_req(OP_ALLOC, 3'($urandom), 10'($urandom));
        end
        default: send_req(OP_ALLOC, 3'($urandom_range(7, i % 3 == 0 ? 0 : 4)),
                          10'($urandom));
      endcase
    end
    s_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Drain and verdict
  initial begin
    wait (stim_done);
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0) $display("buddy_block_allocator_tb: PASS");
    else $display("buddy_block_allocator_tb: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #60ms;
    $display("buddy_block_allocator_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

/* buddy_block_allocator.f */
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bba_node_store.sv
src/bba_ctrl.sv
src/buddy_block_allocator.sv
sim/buddy_block_allocator_tb.sv
